/* design/boot_option_disk_signature_parser_top_macros.svh */
// Assertion macros shared by the boot option disk signature parser modules.
`ifndef BOOT_OPTION_DISK_SIGNATURE_PARSER_TOP_MACROS_SVH
`define BOOT_OPTION_DISK_SIGNATURE_PARSER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BODSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BODSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bodsp_pkg.sv */
// Types and constants for the boot option disk signature parser.
package bodsp_pkg;

    // Item types on the channels
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] part_num;
        logic [63:0] signature_first;
        logic [63:0] signature_second;
    } out_item_t;

    // Status codes
    localparam logic [2:0] STATUS_MBR       = 3'd0;
    localparam logic [2:0] STATUS_GPT       = 3'd1;
    localparam logic [2:0] STATUS_END_PATH  = 3'd2;
    localparam logic [2:0] STATUS_BAD_LEN   = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

    // Device path constants
    localparam logic [7:0]  END_NODE_TYPE    = 8'h7f;
    localparam logic [7:0]  END_NODE_SUBTYPE = 8'hff;
    localparam logic [7:0]  MEDIA_NODE_TYPE  = 8'h04;
    localparam logic [7:0]  HDD_NODE_SUBTYPE = 8'h01;
    localparam logic [15:0] NODE_HDR_BYTES   = 16'd4;
    localparam logic [7:0]  SIG_TYPE_MBR     = 8'h01;
    localparam logic [7:0]  SIG_TYPE_GPT     = 8'h02;

    // Byte offsets
    localparam logic [5:0] HEADER_LAST  = 6'd9;
    localparam logic [5:0] PART_END     = 6'd4;
    localparam logic [5:0] SIG_START    = 6'd20;
    localparam logic [5:0] SIG_END      = 6'd36;
    localparam logic [5:0] DISK_LAST    = 6'd37;

endpackage

/* design/bodsp_core.sv */
// Parser state and per-byte next-state logic for the boot option walker.
`include "boot_option_disk_signature_parser_top_macros.svh"

module bodsp_core
    import bodsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res_item
);

    // Parse phases
    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_DESC_LO = 4'd1;
    localparam logic [3:0] PH_DESC_HI = 4'd2;
    localparam logic [3:0] PH_TYPE    = 4'd3;
    localparam logic [3:0] PH_SUBTYPE = 4'd4;
    localparam logic [3:0] PH_LEN_LO  = 4'd5;
    localparam logic [3:0] PH_LEN_HI  = 4'd6;
    localparam logic [3:0] PH_SKIP    = 4'd7;
    localparam logic [3:0] PH_DISK    = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;

    logic [3:0]       phase_reg,   phase_next;
    logic [5:0]       pos_reg,     pos_next;
    logic [7:0]       low_reg,     low_next;
    logic [7:0]       kind_reg,    kind_next;
    logic [7:0]       subkind_reg, subkind_next;
    logic [15:0]      skip_reg,    skip_next;
    logic [31:0]      part_reg,    part_next;
    logic [1:0][63:0] sig_reg,     sig_next;
    logic             given_reg,   given_next;

    logic [15:0] node_len;
    logic [15:0] skip_count;
    logic [3:0]  sig_idx;
    logic [7:0]  b;

    assign b          = item.data_byte;
    assign node_len   = {b, low_reg};
    assign skip_count = node_len - NODE_HDR_BYTES;
    assign sig_idx    = 4'(pos_reg - SIG_START);

    // Compute next state and any result for the current byte
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        low_next     = low_reg;
        kind_next    = kind_reg;
        subkind_next = subkind_reg;
        skip_next    = skip_reg;
        part_next    = part_reg;
        sig_next     = sig_reg;
        given_next   = given_reg;
        res_valid    = 1'b0;
        res_item     = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg >= HEADER_LAST)
                begin
                    pos_next   = '0;
                    phase_next = PH_DESC_LO;
                end
                else
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
            PH_DESC_LO:
            begin
                low_next   = b;
                phase_next = PH_DESC_HI;
            end
            PH_DESC_HI:
            begin
                phase_next = (low_reg == 8'd0 && b == 8'd0) ? PH_TYPE : PH_DESC_LO;
            end
            PH_TYPE:
            begin
                kind_next  = b;
                phase_next = PH_SUBTYPE;
            end
            PH_SUBTYPE:
            begin
                subkind_next = b;
                if (kind_reg == END_NODE_TYPE && b == END_NODE_SUBTYPE)
                begin
                    res_valid       = 1'b1;
                    res_item.status = STATUS_END_PATH;
                end
                else
                begin
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                low_next   = b;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (node_len < NODE_HDR_BYTES)
                begin
                    res_valid       = 1'b1;
                    res_item.status = STATUS_BAD_LEN;
                end
                else if (kind_reg == MEDIA_NODE_TYPE && subkind_reg == HDD_NODE_SUBTYPE)
                begin
                    pos_next   = '0;
                    phase_next = PH_DISK;
                end
                else
                begin
                    skip_next  = skip_count;
                    phase_next = (skip_count == 16'd0) ? PH_TYPE : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_reg == 16'd1)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_DISK:
            begin
                // Capture partition number and signature bytes
                if (pos_reg < PART_END)
                begin
                    part_next[{pos_reg[1:0], 3'b000} +: 8] = b;
                end
                else if (pos_reg >= SIG_START && pos_reg < SIG_END)
                begin
                    sig_next[sig_idx[3]][{sig_idx[2:0], 3'b000} +: 8] = b;
                end
                // Signature type closes the node
                if (pos_reg >= DISK_LAST)
                begin
                    pos_next = '0;
                    if (b == SIG_TYPE_MBR || b == SIG_TYPE_GPT)
                    begin
                        res_valid                 = 1'b1;
                        res_item.status           = (b == SIG_TYPE_MBR) ? STATUS_MBR
                                                                        : STATUS_GPT;
                        res_item.part_num         = part_reg;
                        res_item.signature_first  = sig_reg[0];
                        res_item.signature_second = sig_reg[1];
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Ignore further bytes of the variable once a result is out
        if (res_valid)
        begin
            phase_next = PH_DONE;
            given_next = 1'b1;
        end

        // Report truncation and restart on the final byte
        if (item.last_byte)
        begin
            if (!res_valid && !given_reg)
            begin
                res_valid       = 1'b1;
                res_item        = '0;
                res_item.status = STATUS_TRUNCATED;
            end
            phase_next   = PH_HEADER;
            pos_next     = '0;
            low_next     = '0;
            kind_next    = '0;
            subkind_next = '0;
            skip_next    = '0;
            part_next    = '0;
            sig_next     = '0;
            given_next   = 1'b0;
        end
    end

    // Advance state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            low_reg     <= '0;
            kind_reg    <= '0;
            subkind_reg <= '0;
            skip_reg    <= '0;
            part_reg    <= '0;
            sig_reg     <= '0;
            given_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            low_reg     <= low_next;
            kind_reg    <= kind_next;
            subkind_reg <= subkind_next;
            skip_reg    <= skip_next;
            part_reg    <= part_next;
            sig_reg     <= sig_next;
            given_reg   <= given_next;
        end
    end

    `BODSP_ASSERT_NOW(a_done_given, phase_reg == PH_DONE, given_reg,
        "done phase without a given result")
    `BODSP_ASSERT_NEXT(a_last_restart, step && item.last_byte,
        phase_reg == PH_HEADER && !given_reg && pos_reg == 6'd0,
        "parser did not restart after final byte")
    `BODSP_ASSERT_NEXT(a_one_result, step && res_valid && !item.last_byte,
        given_reg && phase_reg == PH_DONE,
        "result given without entering done phase")

endmodule

/* design/boot_option_disk_signature_parser_top.sv */
// Boot option disk signature parser: top level with input and result registers.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one byte of a firmware
//   boot option variable per item, with last_byte set on its final byte.
//   Output channel out_valid/out_ready/out_data carries at most one result
//   per variable: MBR or GPT disk found (with partition number and 16-byte
//   signature), end of path, bad node length, or truncation.
//   A byte accepted into the input register is parsed when it steps on,
//   and its result is captured in the result register and shown from it.
//   Throughput: one byte per cycle while no result is stalled by the
//   receiver; the parser updates phase and captures fields per byte.
//   When the receiver stalls a waiting result, the input register still
//   takes one more byte; further bytes wait until the result is taken.
//   Reset (rst_n low, asynchronous) empties both registers and returns the
//   parser to the header-skip phase. After the final byte the parser
//   restarts on its own for the next variable.
`include "boot_option_disk_signature_parser_top_macros.svh"

module boot_option_disk_signature_parser_top
    import bodsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      advance;
    logic      step;
    logic      res_valid;
    out_item_t res_item;

    // Move a byte forward when the result register can take its outcome
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    bodsp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_item_reg <= res_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    `BODSP_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg),
        "input register lost a stalled item")
    `BODSP_ASSERT_NOW(a_no_disk_zero,
        out_valid_reg && (out_item_reg.status == STATUS_END_PATH ||
            out_item_reg.status == STATUS_BAD_LEN ||
            out_item_reg.status == STATUS_TRUNCATED),
        out_item_reg.part_num == 32'd0 && out_item_reg.signature_first == 64'd0 &&
            out_item_reg.signature_second == 64'd0,
        "status without disk carries nonzero fields")
    `BODSP_ASSERT_NEXT(a_out_drain, out_ready && !step,
        !out_valid_reg,
        "result shown without a parsed byte")

endmodule
